// File: hdl/mpc_pkg.sv
// ----------------------------------------------------------------------------
// mpc_pkg
// Shared types and constants of the masked pixel composite block.
// ----------------------------------------------------------------------------
`default_nettype none

package mpc_pkg;

  // Default store geometry.
  localparam int unsigned PIXEL_COUNT_DEF = 4096;
  localparam int unsigned MAX_IMAGES_DEF  = 64;

  // Fixed field widths.
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned QA_W       = 16;
  localparam int unsigned COMP_W     = 24;
  localparam int unsigned CNT_OUT_W  = 7;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned MODE_W     = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COMBINE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALID_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VALID_HIGH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUALITY_ON   = 2'd3;

  // Combine modes; the unused code behaves as mean.
  localparam logic [MODE_W-1:0] MODE_MEAN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MIN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MAX  = 2'd2;

  // Operations.
  localparam logic OP_ACCUMULATE = 1'b0;
  localparam logic OP_FINALIZE   = 1'b1;

  // Quality bits 1 to 3 mark bad data.
  localparam logic [QA_W-1:0] QA_BAD_MASK = 16'h000E;

  localparam int FILL_VALUE = -9999;
  localparam logic signed [COMP_W-1:0] FILL_Q8 = COMP_W'(FILL_VALUE * 256);

  // Register reset values.
  localparam logic signed [SAMPLE_W-1:0] VALID_LOW_RST  = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] VALID_HIGH_RST = 16'sh7FFF;

endpackage

`default_nettype wire

// File: hdl/mpc_ram.sv
// ----------------------------------------------------------------------------
// mpc_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mpc_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/mpc_div.sv
// ----------------------------------------------------------------------------
// mpc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mpc_div #(
  parameter int unsigned NUM_W = 30,
  parameter int unsigned DEN_W = 7
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] numer,
  input  wire logic [DEN_W-1:0] denom,
  output logic                  done,
  output logic      [NUM_W-1:0] quot
);

  localparam int unsigned STEP_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic [NUM_W-1:0]  q_r,    q_nxt;
  logic [DEN_W-1:0]  rem_r,  rem_nxt;
  logic [DEN_W-1:0]  den_r;
  logic [STEP_W-1:0] step_r;
  logic              run_r;
  logic              done_r;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;

  // The dividend shifts out at the top while quotient bits shift in below.
  always_comb begin
    trial = {rem_r, q_r[NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = diff[DEN_W-1:0];
      q_nxt   = {q_r[NUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial[DEN_W-1:0];
      q_nxt   = {q_r[NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(NUM_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= numer;
      rem_r <= '0;
      den_r <= denom;
    end else if (run_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

`default_nettype wire

// File: hdl/masked_pixel_composite.sv
// ----------------------------------------------------------------------------
// masked_pixel_composite
// Per-pixel temporal composite (mean, minimum or maximum) of masked samples.
// ----------------------------------------------------------------------------
// The block holds one memory word per pixel (accumulator, valid count, seen
// flag) and handles one transaction at a time as a read-modify-write of that
// word. After reset a clearing pass writes every word, during which no input
// transaction is taken. An accumulate is the memory read, then the write-back.
// A finalize in minimum or maximum mode, of an empty pixel or of an index
// out of range goes from the read to the result stage. A mean finalize runs
// the bit-serial divider in between, one quotient bit per cycle over 16 +
// log2(MAX_IMAGES) + 8 bits. Finished results sit in an output register, so
// a new input transaction is taken while a result waits to be collected.
`default_nettype none

module masked_pixel_composite
  import mpc_pkg::*;
#(
  parameter int unsigned PIXEL_COUNT = PIXEL_COUNT_DEF,
  parameter int unsigned MAX_IMAGES  = MAX_IMAGES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // input channel
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_operation,
  input  wire logic [IDX_W-1:0]           in_pixel_index,
  input  wire logic signed [SAMPLE_W-1:0] in_sample_value,
  input  wire logic [QA_W-1:0]            in_quality_flags,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [COMP_W-1:0]        out_composite_value,
  output logic [CNT_OUT_W-1:0]            out_valid_count,
  // configuration
  input  wire logic                       cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data
);

  localparam int unsigned ADDR_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_IMAGES + 1);
  localparam int unsigned ACC_W  = SAMPLE_W + $clog2(MAX_IMAGES);
  localparam int unsigned WORD_W = 1 + CNT_W + ACC_W;
  localparam int unsigned NUM_W  = ACC_W + FRAC_W;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_MODIFY = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_PUSH   = 3'd4;

  // Configuration registers.
  logic [MODE_W-1:0]          mode_r;
  logic signed [SAMPLE_W-1:0] valid_low_r;
  logic signed [SAMPLE_W-1:0] valid_high_r;
  logic                       qa_on_r;

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r;

  // Item captured at acceptance.
  logic                       op_r;
  logic                       idx_ok_r;
  logic [ADDR_W-1:0]          addr_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [QA_W-1:0]            qa_r;

  // Pending result.
  logic signed [COMP_W-1:0] res_val_r, res_val_nxt;
  logic [CNT_OUT_W-1:0]     res_cnt_r, res_cnt_nxt;
  logic                     neg_r, neg_nxt;

  logic                       out_valid_r;
  logic signed [COMP_W-1:0]   out_val_r;
  logic [CNT_OUT_W-1:0]       out_cnt_r;

  logic              in_accept;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_rdata;

  logic signed [ACC_W-1:0] acc_rd;
  logic [CNT_W-1:0]        cnt_rd;
  logic                    seen_rd;
  logic signed [ACC_W-1:0] samp_ext;
  logic signed [ACC_W-1:0] acc_new;
  logic [CNT_W-1:0]        cnt_new;
  logic                    sample_ok;
  logic                    mode_min;
  logic                    mode_max;
  logic [NUM_W-1:0]        num_q8;
  logic                    div_start;
  logic [NUM_W-1:0]        div_numer;
  logic                    div_done;
  logic [NUM_W-1:0]        div_quot;
  logic [NUM_W-1:0]        quot_signed;
  logic                    out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_MEAN;
      valid_low_r  <= VALID_LOW_RST;
      valid_high_r <= VALID_HIGH_RST;
      qa_on_r      <= 1'b1;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_COMBINE_MODE: mode_r       <= cfg_data[MODE_W-1:0];
        CFG_VALID_LOW:    valid_low_r  <= cfg_data;
        CFG_VALID_HIGH:   valid_high_r <= cfg_data;
        CFG_QUALITY_ON:   qa_on_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mpc_ram #(
    .WIDTH  (WORD_W),
    .DEPTH  (PIXEL_COUNT),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (in_accept),
    .rd_addr (ADDR_W'(in_pixel_index)),
    .rd_data (mem_rdata)
  );

  assign acc_rd   = mem_rdata[ACC_W-1:0];
  assign cnt_rd   = mem_rdata[ACC_W +: CNT_W];
  assign seen_rd  = mem_rdata[WORD_W-1];
  assign samp_ext = ACC_W'(sample_r);
  assign mode_min = (mode_r == MODE_MIN);
  assign mode_max = (mode_r == MODE_MAX);
  assign num_q8   = {acc_rd, {FRAC_W{1'b0}}};

  always_comb begin
    sample_ok = (sample_r >= valid_low_r) && (sample_r <= valid_high_r);
    if (qa_on_r && ((qa_r & QA_BAD_MASK) != '0)) begin
      sample_ok = 1'b0;
    end
  end

  // Fold of one sample into the stored accumulator.
  always_comb begin
    acc_new = acc_rd;
    cnt_new = cnt_rd;
    if (sample_ok && (cnt_rd < CNT_W'(MAX_IMAGES))) begin
      cnt_new = cnt_rd + 1'b1;
      priority if (cnt_rd == '0) begin
        acc_new = samp_ext;
      end else if (mode_min) begin
        acc_new = (samp_ext < acc_rd) ? samp_ext : acc_rd;
      end else if (mode_max) begin
        acc_new = (samp_ext > acc_rd) ? samp_ext : acc_rd;
      end else begin
        acc_new = acc_rd + samp_ext;
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    res_val_nxt = res_val_r;
    res_cnt_nxt = res_cnt_r;
    neg_nxt     = neg_r;
    mem_we      = 1'b0;
    mem_waddr   = addr_r;
    mem_wdata   = '0;
    div_start   = 1'b0;
    div_numer   = num_q8[NUM_W-1] ? (~num_q8 + 1'b1) : num_q8;
    quot_signed = neg_r ? (~div_quot + 1'b1) : div_quot;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        if (clr_addr_r == ADDR_W'(PIXEL_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_MODIFY;
        end
      end
      ST_MODIFY: begin
        if (op_r == OP_ACCUMULATE) begin
          mem_we    = idx_ok_r;
          mem_wdata = {1'b1, cnt_new, acc_new};
          state_nxt = ST_IDLE;
        end else begin
          // A finalize clears the entry as it reads it out.
          mem_we      = idx_ok_r;
          mem_wdata   = '0;
          res_cnt_nxt = CNT_OUT_W'(cnt_rd);
          neg_nxt     = num_q8[NUM_W-1];
          state_nxt   = ST_PUSH;
          priority if (!idx_ok_r) begin
            res_val_nxt = '0;
            res_cnt_nxt = '0;
          end else if (cnt_rd != '0 && (mode_min || mode_max)) begin
            res_val_nxt = {acc_rd[SAMPLE_W-1:0], {FRAC_W{1'b0}}};
          end else if (cnt_rd != '0) begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end else if (seen_rd) begin
            res_val_nxt = FILL_Q8;
          end else begin
            res_val_nxt = '0;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_val_nxt = COMP_W'(quot_signed);
          state_nxt   = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (state_r == ST_PUSH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r     <= in_operation;
      idx_ok_r <= (32'(in_pixel_index) < 32'(PIXEL_COUNT));
      addr_r   <= ADDR_W'(in_pixel_index);
      sample_r <= in_sample_value;
      qa_r     <= in_quality_flags;
    end
    res_val_r <= res_val_nxt;
    res_cnt_r <= res_cnt_nxt;
    neg_r     <= neg_nxt;
    if (state_r == ST_PUSH && out_free) begin
      out_val_r <= res_val_r;
      out_cnt_r <= res_cnt_r;
    end
  end

  mpc_div #(
    .NUM_W (NUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (div_numer),
    .denom (cnt_rd),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign out_valid           = out_valid_r;
  assign out_composite_value = out_val_r;
  assign out_valid_count     = out_cnt_r;

endmodule

`default_nettype wire
